### design/novcs_pkg.sv
// Shared types and constants for the NoC output port VC scheduler.
// Holds the request structs, the stored flit format and the encodings.
// No dependencies.
package novcs_pkg;

    // Default sizing of the output port.
    localparam int DEF_NUM_PORTS    = 5;
    localparam int DEF_NUM_CHANNELS = 4;

    // Request operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_FLIT = 1'b1;

    // Flit kind encodings.
    localparam logic [1:0] HEAD = 2'd0;
    localparam logic [1:0] DATA = 2'd1;
    localparam logic [1:0] TAIL = 2'd2;
    localparam logic [1:0] HDT  = 2'd3;

    // Network flit marker.
    localparam logic NOC = 1'b1;

    // Priority classes carried in the flit.
    localparam logic [1:0] PRIO_BE = 2'd0;
    localparam logic [1:0] PRIO_GT = 2'd1;

    // Statistics class selector values.
    localparam logic [1:0] CLS_ALL = 2'd0;
    localparam logic [1:0] CLS_GT  = 2'd1;
    localparam logic [1:0] CLS_BE  = 2'd2;
    localparam int         NUM_CLS = 3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_CORE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATS_CLASS = 1'b1;

    // Input request.
    typedef struct packed {
        logic        operation;
        logic [2:0]  in_port;
        logic [1:0]  vc_id;
        logic [1:0]  flit_kind;
        logic [1:0]  prio_class;
        logic        is_noc;
        logic [31:0] entry_stamp;
        logic [23:0] payload;
        logic [3:0]  credit_free;
    } t_in_item;

    // Result request.
    typedef struct packed {
        logic        out_valid;
        logic [1:0]  out_vc;
        logic [1:0]  out_kind;
        logic [1:0]  out_prio;
        logic        out_is_noc;
        logic [23:0] out_payload;
        logic [31:0] out_stamp;
        logic [4:0]  ready_mask;
        logic [31:0] pkt_total;
        logic [31:0] flit_total;
        logic [47:0] latency_total;
    } t_out_item;

    // Flit as kept in a holding or VC register.
    typedef struct packed {
        logic [1:0]  vc;
        logic [1:0]  kind;
        logic [1:0]  prio;
        logic        noc;
        logic [31:0] stamp;
        logic [23:0] payload;
    } t_flit;

endpackage

### design/noc_output_port_vc_scheduler.sv
// Router output port: per-port holding registers, per-VC output registers,
// round-robin VC slot service with downstream credit check and statistics.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while the output is not stalled; all state updates in one pass of logic.
// The output register lets a new request in while the result is being taken.
// Reset (synchronous, active low) clears counters, busy bits and configuration.
// Depends on novcs_pkg.
module noc_output_port_vc_scheduler #(
    parameter int NUM_PORTS    = novcs_pkg::DEF_NUM_PORTS,
    parameter int NUM_CHANNELS = novcs_pkg::DEF_NUM_CHANNELS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  novcs_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output novcs_pkg::t_out_item                  o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [novcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [novcs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [7:0] PORT_MASK = 8'((9'd1 << NUM_PORTS) - 9'd1);

    // Configuration.
    logic       r_is_core;
    logic [1:0] r_stats_class;

    // Control state.
    logic [31:0]             r_cycle, n_cycle;
    logic [CW-1:0]           r_slot, n_slot;
    logic [NUM_CHANNELS-1:0] r_vc_busy, n_vc_busy;
    logic [NUM_PORTS-1:0]    r_hold_busy, n_hold_busy;
    logic [31:0]             r_pkt  [novcs_pkg::NUM_CLS];
    logic [31:0]             n_pkt  [novcs_pkg::NUM_CLS];
    logic [31:0]             r_flits[novcs_pkg::NUM_CLS];
    logic [31:0]             n_flits[novcs_pkg::NUM_CLS];
    logic [47:0]             r_lat  [novcs_pkg::NUM_CLS];
    logic [47:0]             n_lat  [novcs_pkg::NUM_CLS];

    // Flit storage.
    novcs_pkg::t_flit r_vc_flit  [NUM_CHANNELS];
    novcs_pkg::t_flit n_vc_flit  [NUM_CHANNELS];
    novcs_pkg::t_flit r_hold_flit[NUM_PORTS];
    novcs_pkg::t_flit n_hold_flit[NUM_PORTS];

    // Output register.
    logic                 r_out_valid;
    novcs_pkg::t_out_item r_out_data, n_out_data;

    logic             w_in_acc;
    logic [3:0]       w_vc_red;
    logic [PW-1:0]    w_port;
    logic [CW-1:0]    w_vidx;
    logic [CW-1:0]    w_hidx;
    logic             w_send;
    novcs_pkg::t_flit w_sflit;
    novcs_pkg::t_flit w_new_flit;
    logic [31:0]      w_lat32;
    logic [47:0]      w_lat48;
    logic [7:0]       w_busy_pad;

    // Handshake: the output register frees up when its result is taken.
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Arriving VC number reduced modulo the channel count (value below four).
    always_comb begin
        w_vc_red = {2'b00, i_in_data.vc_id};
        for (int k = 0; k < 3; k++) begin
            if (w_vc_red >= 4'(NUM_CHANNELS)) begin
                w_vc_red = w_vc_red - 4'(NUM_CHANNELS);
            end
        end
    end

    assign w_port = PW'(i_in_data.in_port);

    always_comb begin
        w_new_flit.vc      = w_vc_red[1:0];
        w_new_flit.kind    = i_in_data.flit_kind;
        w_new_flit.prio    = i_in_data.prio_class;
        w_new_flit.noc     = i_in_data.is_noc;
        w_new_flit.stamp   = i_in_data.entry_stamp;
        w_new_flit.payload = i_in_data.payload;
    end

    // Next state and result for one request.
    always_comb begin
        n_cycle     = r_cycle;
        n_slot      = r_slot;
        n_vc_busy   = r_vc_busy;
        n_hold_busy = r_hold_busy;
        n_vc_flit   = r_vc_flit;
        n_hold_flit = r_hold_flit;
        n_pkt       = r_pkt;
        n_flits     = r_flits;
        n_lat       = r_lat;
        n_out_data  = '0;
        w_send      = 1'b0;
        w_sflit     = r_vc_flit[0];
        w_lat32     = '0;
        w_lat48     = '0;
        w_vidx      = CW'(w_vc_red[1:0]);
        w_hidx      = '0;

        if (i_in_data.operation == novcs_pkg::OP_TICK) begin
            // Advance the cycle counter and the VC slot; the slot restarts at
            // zero when the counter wraps so it tracks count mod channels.
            n_cycle = r_cycle + 32'd1;
            if (n_cycle == 32'd0 || r_slot == CW'(NUM_CHANNELS - 1)) begin
                n_slot = '0;
            end else begin
                n_slot = r_slot + CW'(1);
            end

            // Serve the slot if it holds a flit and credit allows or the port is a core port.
            w_sflit = r_vc_flit[n_slot];
            if (r_vc_busy[n_slot] &&
                (r_is_core || i_in_data.credit_free[w_sflit.vc])) begin
                w_send                 = 1'b1;
                n_vc_busy[n_slot]      = 1'b0;
                n_out_data.out_valid   = 1'b1;
                n_out_data.out_vc      = w_sflit.vc;
                n_out_data.out_kind    = w_sflit.kind;
                n_out_data.out_prio    = w_sflit.prio;
                n_out_data.out_is_noc  = w_sflit.noc;
                n_out_data.out_payload = w_sflit.payload;
                n_out_data.out_stamp   = r_is_core ? w_sflit.stamp : n_cycle;
            end

            // Statistics for a sent network flit.
            w_lat32 = n_cycle - 32'd1 - w_sflit.stamp;
            w_lat48 = {16'd0, w_lat32};
            if (w_send && w_sflit.noc == novcs_pkg::NOC) begin
                if (w_sflit.kind == novcs_pkg::TAIL || w_sflit.kind == novcs_pkg::HDT) begin
                    n_lat[novcs_pkg::CLS_ALL] = r_lat[novcs_pkg::CLS_ALL] + w_lat48;
                    n_pkt[novcs_pkg::CLS_ALL] = r_pkt[novcs_pkg::CLS_ALL] + 32'd1;
                    if (w_sflit.prio == novcs_pkg::PRIO_GT) begin
                        n_lat[novcs_pkg::CLS_GT] = r_lat[novcs_pkg::CLS_GT] + w_lat48;
                        n_pkt[novcs_pkg::CLS_GT] = r_pkt[novcs_pkg::CLS_GT] + 32'd1;
                    end else if (w_sflit.prio == novcs_pkg::PRIO_BE) begin
                        n_lat[novcs_pkg::CLS_BE] = r_lat[novcs_pkg::CLS_BE] + w_lat48;
                        n_pkt[novcs_pkg::CLS_BE] = r_pkt[novcs_pkg::CLS_BE] + 32'd1;
                    end
                end
                n_flits[novcs_pkg::CLS_ALL] = r_flits[novcs_pkg::CLS_ALL] + 32'd1;
                if (w_sflit.prio == novcs_pkg::PRIO_GT) begin
                    n_flits[novcs_pkg::CLS_GT] = r_flits[novcs_pkg::CLS_GT] + 32'd1;
                end else if (w_sflit.prio == novcs_pkg::PRIO_BE) begin
                    n_flits[novcs_pkg::CLS_BE] = r_flits[novcs_pkg::CLS_BE] + 32'd1;
                end
            end

            // Move waiting flits into free VC registers, lowest port first.
            for (int p = 0; p < NUM_PORTS; p++) begin
                w_hidx = CW'(r_hold_flit[p].vc);
                if (r_hold_busy[p] && !n_vc_busy[w_hidx]) begin
                    n_vc_flit[w_hidx] = r_hold_flit[p];
                    n_vc_busy[w_hidx] = 1'b1;
                    n_hold_busy[p]    = 1'b0;
                end
            end
        end else if ({1'b0, i_in_data.in_port} < 4'(NUM_PORTS)) begin
            // Flit arrival: write it into its VC register if free, else into its port's holding register.
            if (!r_vc_busy[w_vidx]) begin
                n_vc_flit[w_vidx]   = w_new_flit;
                n_vc_busy[w_vidx]   = 1'b1;
                n_hold_busy[w_port] = 1'b0;
            end else begin
                n_hold_flit[w_port] = w_new_flit;
                n_hold_busy[w_port] = 1'b1;
            end
        end

        // Holding register status and the selected counter set.
        w_busy_pad            = 8'(n_hold_busy);
        n_out_data.ready_mask = 5'(~w_busy_pad & PORT_MASK);
        case (r_stats_class)
            novcs_pkg::CLS_ALL, novcs_pkg::CLS_GT, novcs_pkg::CLS_BE: begin
                n_out_data.pkt_total     = n_pkt[r_stats_class];
                n_out_data.flit_total    = n_flits[r_stats_class];
                n_out_data.latency_total = n_lat[r_stats_class];
            end
            default: begin
                n_out_data.pkt_total     = '0;
                n_out_data.flit_total    = '0;
                n_out_data.latency_total = '0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_core     <= 1'b0;
            r_stats_class <= novcs_pkg::CLS_ALL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                novcs_pkg::CFG_IS_CORE:     r_is_core     <= i_cfg_wdata[0];
                novcs_pkg::CFG_STATS_CLASS: r_stats_class <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle     <= '0;
            r_slot      <= '0;
            r_vc_busy   <= '0;
            r_hold_busy <= '0;
            for (int c = 0; c < novcs_pkg::NUM_CLS; c++) begin
                r_pkt[c]   <= '0;
                r_flits[c] <= '0;
                r_lat[c]   <= '0;
            end
        end else if (w_in_acc) begin
            r_cycle     <= n_cycle;
            r_slot      <= n_slot;
            r_vc_busy   <= n_vc_busy;
            r_hold_busy <= n_hold_busy;
            r_pkt       <= n_pkt;
            r_flits     <= n_flits;
            r_lat       <= n_lat;
        end
    end

    // Flit storage, read only while its busy bit is set.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_vc_flit   <= n_vc_flit;
            r_hold_flit <= n_hold_flit;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    // Every accepted request leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted request produced no result");

    // A tick advances the cycle counter by exactly one.
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.operation == novcs_pkg::OP_TICK)
        |=> r_cycle == $past(r_cycle) + 32'd1)
        else $error("cycle counter did not advance on a tick");

    // A flit arrival never sends a flit.
    a_flit_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.operation == novcs_pkg::OP_FLIT)
        |=> !r_out_data.out_valid)
        else $error("flit arrival reported a send");

    // A send only happens from a VC register that holds a flit.
    a_send_had_flit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_send) |-> r_vc_busy[n_slot])
        else $error("send from an empty VC register");

    // Without a send, the payload and stamp of the result are zero.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.out_valid)
        |-> (r_out_data.out_payload == 24'd0 && r_out_data.out_stamp == 32'd0))
        else $error("flit fields set without a send");

endmodule
